// ===== src/mcoat_pkg.sv =====
// Shared types and constants of the multi-channel one-shot actuator timer.
package mcoat_pkg;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic signed [31:0] NO_ID = -32'sd1;

  localparam int FIFO_D  = 4;
  localparam int FIFO_AW = 2;

  typedef enum logic [1:0] {
    KIND_STARTED   = 2'd0,
    KIND_REJECTED  = 2'd1,
    KIND_FINISHED  = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_t;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         channel;
    logic signed [31:0] command_id;
    logic [30:0]        duration_ms;
  } mcoat_in_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         channel_res;
    logic signed [31:0] finished_id;
    logic [3:0]         drive_mask;
    logic               last;
  } mcoat_res_t;

endpackage

// ===== src/mcoat_ifs.sv =====
// Valid/ready channel interfaces for the timer's input items and result items.
interface mcoat_in_if import mcoat_pkg::*; ();
  logic      valid;
  logic      ready;
  mcoat_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcoat_out_if import mcoat_pkg::*; ();
  logic       valid;
  logic       ready;
  mcoat_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/multi_channel_oneshot_actuator_timer.sv =====
// Top level of the multi-channel one-shot actuator timer.
//
// Input channel in_if carries start items (cmd = 1) and tick items (cmd = 0).
// Result channel out_if carries one result per start and one or more per tick;
// the final result of every input item has last set.
// An item passes a three-stage front end (two stages convert milliseconds to
// ticks by reciprocal multiplication and correction) and then executes.
// A start executes in the idle state. A tick advances the time count, sweeps the
// timer memory one channel per cycle through its single read port while queue
// space allows, compares each entry once its read is registered, closes the sweep
// after the last compare and then emits the final result.
// Input transfers continue while an earlier item is still executing.
// Results go through a four-entry output queue; when the receiver stalls, the
// sweep holds its reads until queue space is reserved, and the front end
// backs up into in_if.ready. No result is dropped.
// Reset clears the time count, all channel outputs and the queue. Timer memory
// entries are only used for active channels, so it needs no clearing pass.
module multi_channel_oneshot_actuator_timer import mcoat_pkg::*; #(
  parameter int CHANNELS       = 4,
  parameter int TICK_PERIOD_MS = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  mcoat_in_if.sink       in_if,
  mcoat_out_if.source    out_if
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int TP_LG  = $clog2(TICK_PERIOD_MS);
  localparam int DIV_SH = 31 + TP_LG;
  localparam logic [31:0] RECIP = 32'((64'd1 << DIV_SH) / 64'(TICK_PERIOD_MS));
  localparam logic [30:0] TP31  = 31'(TICK_PERIOD_MS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FLUSH = 3'b100
  } st_t;

  typedef struct packed {
    logic [31:0]        end_time;
    logic signed [31:0] id;
  } tmr_ent_t;

  function automatic logic [3:0] drive_of(logic [CHANNELS-1:0] a);
    logic [CHANNELS+3:0] p;
    p = {4'b0000, a};
    return p[3:0];
  endfunction

  logic               s1_v_r;
  logic               s1_cmd_r;
  logic [2:0]         s1_ch_r;
  logic signed [31:0] s1_id_r;
  logic [30:0]        s1_dur_r;
  logic [62:0]        s1_prod_r;

  logic               s2_v_r;
  logic               s2_cmd_r;
  logic [2:0]         s2_ch_r;
  logic signed [31:0] s2_id_r;
  logic [30:0]        s2_q_r;

  logic               s3_v_r;
  logic               s3_cmd_r;
  logic [2:0]         s3_ch_r;
  logic signed [31:0] s3_id_r;
  logic [30:0]        s3_q_r;

  logic adv1, adv2, adv3, s3_done;

  logic [30:0] q0, prod2, rem, q_fix;

  st_t                 st_r, st_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;
  logic [31:0]         time_r, time_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic [CH_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                hold_v_r, hold_v_nxt;
  mcoat_res_t          hold_r, hold_nxt;

  tmr_ent_t        tmr_mem [CHANNELS];
  tmr_ent_t        mem_q_r;
  tmr_ent_t        mem_wd;
  logic            mem_we, mem_re;
  logic [CH_W-1:0] ch_addr;
  logic            ch_ok;
  logic [31:0]     ticks;

  mcoat_res_t         fifo_mem [FIFO_D];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               push, pop, fifo_full;
  mcoat_res_t         push_d;

  assign adv3 = !s3_v_r || s3_done;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_if.ready = adv1;

  assign q0    = 31'(s1_prod_r >> DIV_SH);
  assign prod2 = 31'(q0 * TP31);
  assign rem   = s1_dur_r - prod2;
  assign q_fix = (rem >= TP31) ? q0 + 31'd1 : q0;

  assign ch_ok   = 32'(s3_ch_r) < 32'(CHANNELS);
  assign ch_addr = CH_W'(s3_ch_r);
  assign ticks   = (s3_q_r == '0) ? 32'd1 : 32'(s3_q_r);
  assign mem_wd  = '{end_time: time_r + ticks, id: s3_id_r};

  assign fifo_full  = cnt_r == (FIFO_AW+1)'(FIFO_D);
  assign pop        = out_if.valid && out_if.ready;
  assign out_if.valid = cnt_r != '0;
  assign out_if.data  = fifo_mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= in_if.valid;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_cmd_r  <= in_if.data.cmd;
      s1_ch_r   <= in_if.data.channel;
      s1_id_r   <= in_if.data.command_id;
      s1_dur_r  <= in_if.data.duration_ms;
      s1_prod_r <= 63'(in_if.data.duration_ms) * 63'(RECIP);
    end
    if (adv2) begin
      s2_cmd_r <= s1_cmd_r;
      s2_ch_r  <= s1_ch_r;
      s2_id_r  <= s1_id_r;
      s2_q_r   <= q_fix;
    end
    if (adv3) begin
      s3_cmd_r <= s2_cmd_r;
      s3_ch_r  <= s2_ch_r;
      s3_id_r  <= s2_id_r;
      s3_q_r   <= s2_q_r;
    end
  end

  always_comb begin
    active_nxt = active_r;
    time_nxt   = time_r;
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    rd_v_nxt   = 1'b0;
    rd_idx_nxt = rd_idx_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    push       = 1'b0;
    push_d     = hold_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    s3_done    = 1'b0;

    if (rd_v_r && active_r[rd_idx_r] && (mem_q_r.end_time <= time_r)) begin
      active_nxt[rd_idx_r] = 1'b0;
      if (mem_q_r.id != NO_ID) begin
        if (hold_v_r) begin
          push   = 1'b1;
          push_d = hold_r;
        end
        hold_v_nxt = 1'b1;
        hold_nxt   = '{kind: KIND_FINISHED, channel_res: 3'(rd_idx_r),
                       finished_id: mem_q_r.id, drive_mask: drive_of(active_nxt),
                       last: 1'b0};
      end
    end

    unique case (st_r)
      ST_IDLE: begin
        if (s3_v_r) begin
          if (s3_cmd_r == CMD_START) begin
            if (!fifo_full) begin
              push    = 1'b1;
              s3_done = 1'b1;
              if (ch_ok) begin
                active_nxt[ch_addr] = 1'b1;
                mem_we = 1'b1;
                push_d = '{kind: KIND_STARTED, channel_res: s3_ch_r,
                           finished_id: s3_id_r, drive_mask: drive_of(active_nxt),
                           last: 1'b1};
              end else begin
                push_d = '{kind: KIND_REJECTED, channel_res: s3_ch_r,
                           finished_id: s3_id_r, drive_mask: drive_of(active_nxt),
                           last: 1'b1};
              end
            end
          end else begin
            time_nxt   = time_r + 32'd1;
            idx_nxt    = '0;
            hold_v_nxt = 1'b0;
            st_nxt     = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (32'(idx_r) < 32'(CHANNELS)) begin
          if (({1'b0, cnt_r} + (FIFO_AW+2)'(rd_v_r)) < (FIFO_AW+2)'(FIFO_D)) begin
            mem_re     = 1'b1;
            rd_v_nxt   = 1'b1;
            rd_idx_nxt = idx_r[CH_W-1:0];
            idx_nxt    = idx_r + CNT_W'(1);
          end
        end else if (!rd_v_r) begin
          st_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!fifo_full) begin
          push = 1'b1;
          if (hold_v_r) begin
            push_d      = hold_r;
            push_d.last = 1'b1;
          end else begin
            push_d = '{kind: KIND_IDLE_TICK, channel_res: 3'd0, finished_id: NO_ID,
                       drive_mask: drive_of(active_nxt), last: 1'b1};
          end
          hold_v_nxt = 1'b0;
          s3_done    = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      active_r <= '0;
      time_r   <= '0;
      idx_r    <= '0;
      rd_v_r   <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      active_r <= active_nxt;
      time_r   <= time_nxt;
      idx_r    <= idx_nxt;
      rd_v_r   <= rd_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    hold_r   <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tmr_mem[ch_addr] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= tmr_mem[idx_r[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wp_r] <= push_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

endmodule
